FILE: hdl/rtnb_pkg.sv
// Shared types, widths and helpers for the radix tree node builder.
package rtnb_pkg;

    localparam int CODE_W  = 32;  // Morton code width
    localparam int IDX_W   = 10;  // item and result index width
    localparam int CNT_W   = 11;  // object count and internal leaf position width
    localparam int LEN_W   = 12;  // search stride and offset width
    localparam int PROBE_W = 13;  // signed probe position width
    localparam int PFX_W   = 6;   // common prefix length, 0 to 32

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_BUILD = 1'b1
    } cmd_t;

    typedef logic signed [PROBE_W-1:0] probe_t;

    typedef struct packed {
        cmd_t              command;
        logic [IDX_W-1:0]  item_index;
        logic [CODE_W-1:0] morton_code;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] range_first;
        logic [IDX_W-1:0] range_last;
        logic [IDX_W-1:0] split_position;
        logic             left_is_leaf;
        logic             right_is_leaf;
    } rsp_t;

    // Result of one pass through the prefix unit
    typedef struct packed {
        logic [PFX_W-1:0] len;
        logic             equal;
    } pfx_t;

    function automatic probe_t to_probe(logic [CNT_W-1:0] pos);
        to_probe = probe_t'({{(PROBE_W-CNT_W){1'b0}}, pos});
    endfunction

endpackage

FILE: hdl/rtnb_prefix_unit.sv
// Shared common-prefix unit: leading zeros of the XOR of two codes.
module rtnb_prefix_unit (
    input  logic [rtnb_pkg::CODE_W-1:0] a,
    input  logic [rtnb_pkg::CODE_W-1:0] b,
    output rtnb_pkg::pfx_t              res
);

    logic [rtnb_pkg::CODE_W-1:0] diff;
    logic [rtnb_pkg::PFX_W-1:0]  lz;

    assign diff = a ^ b;

    // Priority encode: the highest set bit wins, no bit set gives full width
    always_comb
    begin
        lz = rtnb_pkg::PFX_W'(rtnb_pkg::CODE_W);
        for (int i = 0; i < rtnb_pkg::CODE_W; i++)
        begin
            if (diff[i])
            begin
                lz = rtnb_pkg::PFX_W'(rtnb_pkg::CODE_W - 1 - i);
            end
        end
    end

    assign res.len   = lz;
    assign res.equal = (diff == '0);

endmodule

FILE: hdl/radix_tree_node_builder_unit.sv
// Radix tree internal node builder: code store, search sequencer and result register.
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+-------------------------------------
//  req     | in        | req_valid / req_ready | command, item_index, morton_code
//  rsp     | out       | rsp_valid / rsp_ready | node, range, split, leaf flags
//  cfg     | in        | cfg_write_en          | object_count (write only)
//
//  A build issues every code-store read through the one registered read port, and a
//  node inside a run of equal codes reads each further code of the run as it scans upward.
//  req_ready is high only while the sequencer is idle; a finished result waits in
//  the output register, and a build that ends while it is still untaken holds until then.
//  Reset clears the sequencer, the result valid and object_count (to 1024); the
//  code store is not cleared and needs no clearing pass.
module radix_tree_node_builder_unit #(
    parameter int MAX_OBJECTS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  rtnb_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output rtnb_pkg::rsp_t             rsp,
    input  logic                       cfg_write_en,
    input  logic [rtnb_pkg::CNT_W-1:0] cfg_write_data
);

    localparam int AW        = $clog2(MAX_OBJECTS);
    localparam int CNT_LIMIT = (MAX_OBJECTS > 2047) ? 2047 : MAX_OBJECTS;
    localparam logic [rtnb_pkg::CNT_W-1:0] CNT_MAX = rtnb_pkg::CNT_W'(CNT_LIMIT);
    localparam logic [rtnb_pkg::CNT_W-1:0] CNT_MIN = rtnb_pkg::CNT_W'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_RG_C,
        S_RG_DOWN,
        S_RG_UP,
        S_SCAN,
        S_EXP_STEP,
        S_EXP_EVAL,
        S_BIN_STEP,
        S_BIN_EVAL,
        S_SP_START,
        S_SP_FC,
        S_SP_LC,
        S_SP_STEP,
        S_SP_EVAL,
        S_DONE
    } state_t;

    typedef logic [rtnb_pkg::CNT_W-1:0] pos_t;
    typedef logic [rtnb_pkg::LEN_W-1:0] len_t;

    // control
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   rsp_valid_reg, rsp_valid_next;
    pos_t   object_count_reg;

    // payload
    logic [rtnb_pkg::CODE_W-1:0] base_reg, base_next;
    logic [rtnb_pkg::PFX_W-1:0]  pd_reg, pd_next;
    logic [rtnb_pkg::PFX_W-1:0]  dmin_reg, dmin_next;
    logic [rtnb_pkg::PFX_W-1:0]  common_reg, common_next;
    logic                        eqd_reg, eqd_next;
    logic                        dir_neg_reg, dir_neg_next;
    len_t                        lmax_reg, lmax_next;
    len_t                        l_reg, l_next;
    len_t                        t_reg, t_next;
    pos_t                        step_reg, step_next;
    rtnb_pkg::probe_t            addr_reg, addr_next;
    pos_t                        idx_reg, idx_next;
    pos_t                        top_reg, top_next;
    pos_t                        j_reg, j_next;
    pos_t                        first_reg, first_next;
    pos_t                        last_reg, last_next;
    pos_t                        split_reg, split_next;
    rtnb_pkg::rsp_t              rsp_reg;

    // code store
    logic [rtnb_pkg::CODE_W-1:0] mem [MAX_OBJECTS];
    logic [rtnb_pkg::CODE_W-1:0] rdata_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;

    rtnb_pkg::pfx_t   pfx;
    pos_t             count_clamp;
    pos_t             top_w;
    len_t             len_sel;
    rtnb_pkg::probe_t probe_w;
    logic             probe_ok;
    logic [rtnb_pkg::CNT_W:0] mid_sum;
    logic [rtnb_pkg::CNT_W:0] step_sum;
    pos_t             step_half;
    logic [rtnb_pkg::CNT_W:0] cand_sum;
    logic             rsp_load;
    logic             load_ok;

    rtnb_prefix_unit u_prefix (
        .a   (base_reg),
        .b   (rdata_reg),
        .res (pfx)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (object_count_reg < CNT_MIN)
        begin
            count_clamp = CNT_MIN;
        end
        else if (object_count_reg > CNT_MAX)
        begin
            count_clamp = CNT_MAX;
        end
        else
        begin
            count_clamp = object_count_reg;
        end
    end

    assign top_w     = count_clamp - 1'b1;
    assign load_ok   = (32'(req.item_index) < 32'(MAX_OBJECTS));
    assign mem_waddr = AW'(req.item_index);
    assign mem_raddr = AW'($unsigned(addr_reg));

    // Shared probe adder: node index plus or minus the current offset
    always_comb
    begin
        unique case (state_reg)
            S_BIN_STEP:
            begin
                len_sel = (t_reg == '0) ? l_reg : (l_reg + t_reg);
            end
            default:
            begin
                len_sel = lmax_reg;
            end
        endcase
    end

    assign probe_w = dir_neg_reg
                   ? (rtnb_pkg::to_probe(idx_reg) - rtnb_pkg::probe_t'({1'b0, len_sel}))
                   : (rtnb_pkg::to_probe(idx_reg) + rtnb_pkg::probe_t'({1'b0, len_sel}));
    assign probe_ok = (probe_w >= 0) && (probe_w <= rtnb_pkg::to_probe(top_reg));

    assign mid_sum   = {1'b0, first_reg} + {1'b0, last_reg};
    assign step_sum  = {1'b0, step_reg} + 1'b1;
    assign step_half = step_sum[rtnb_pkg::CNT_W:1];
    assign cand_sum  = {1'b0, split_reg} + {1'b0, step_half};

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        rsp_valid_next = rsp_valid_reg;
        base_next      = base_reg;
        pd_next        = pd_reg;
        dmin_next      = dmin_reg;
        common_next    = common_reg;
        eqd_next       = eqd_reg;
        dir_neg_next   = dir_neg_reg;
        lmax_next      = lmax_reg;
        l_next         = l_reg;
        t_next         = t_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        top_next       = top_reg;
        j_next         = j_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        split_next     = split_reg;
        mem_we         = 1'b0;
        rsp_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next = {1'b0, req.item_index};
                    top_next = top_w;
                    if (req.command == rtnb_pkg::CMD_LOAD)
                    begin
                        mem_we = load_ok;
                    end
                    else if ({1'b0, req.item_index} >= top_w)
                    begin
                        // no such internal node: drop
                        state_next = S_IDLE;
                    end
                    else if (req.item_index == '0)
                    begin
                        first_next = '0;
                        last_next  = top_w;
                        state_next = S_SP_START;
                    end
                    else
                    begin
                        addr_next  = rtnb_pkg::to_probe({1'b0, req.item_index});
                        ret_next   = S_RG_C;
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = ret_reg;
            end

            S_RG_C:
            begin
                base_next  = rdata_reg;
                addr_next  = rtnb_pkg::to_probe(idx_reg) - rtnb_pkg::probe_t'(1);
                ret_next   = S_RG_DOWN;
                state_next = S_READ;
            end

            S_RG_DOWN:
            begin
                pd_next    = pfx.len;
                eqd_next   = pfx.equal;
                addr_next  = rtnb_pkg::to_probe(idx_reg) + rtnb_pkg::probe_t'(1);
                ret_next   = S_RG_UP;
                state_next = S_READ;
            end

            S_RG_UP:
            begin
                if (eqd_reg && pfx.equal)
                begin
                    // equal run: scan upward from the next code
                    j_next    = idx_reg + 1'b1;
                    base_next = rdata_reg;
                    if ((idx_reg + 1'b1) >= top_reg)
                    begin
                        first_next = idx_reg;
                        last_next  = idx_reg + 1'b1;
                        state_next = S_SP_START;
                    end
                    else
                    begin
                        addr_next  = rtnb_pkg::to_probe(idx_reg) + rtnb_pkg::probe_t'(2);
                        ret_next   = S_SCAN;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    if (pfx.len < pd_reg)
                    begin
                        dir_neg_next = 1'b1;
                        dmin_next    = pfx.len;
                    end
                    else
                    begin
                        dir_neg_next = 1'b0;
                        dmin_next    = pd_reg;
                    end
                    lmax_next  = rtnb_pkg::LEN_W'(2);
                    state_next = S_EXP_STEP;
                end
            end

            S_SCAN:
            begin
                if (!pfx.equal)
                begin
                    first_next = idx_reg;
                    last_next  = j_reg;
                    state_next = S_SP_START;
                end
                else
                begin
                    j_next    = j_reg + 1'b1;
                    base_next = rdata_reg;
                    if ((j_reg + 1'b1) >= top_reg)
                    begin
                        first_next = idx_reg;
                        last_next  = j_reg + 1'b1;
                        state_next = S_SP_START;
                    end
                    else
                    begin
                        addr_next  = rtnb_pkg::to_probe(j_reg + 1'b1) + rtnb_pkg::probe_t'(1);
                        ret_next   = S_SCAN;
                        state_next = S_READ;
                    end
                end
            end

            S_EXP_STEP:
            begin
                if (probe_ok)
                begin
                    addr_next  = probe_w;
                    ret_next   = S_EXP_EVAL;
                    state_next = S_READ;
                end
                else
                begin
                    l_next     = '0;
                    t_next     = lmax_reg >> 1;
                    state_next = S_BIN_STEP;
                end
            end

            S_EXP_EVAL:
            begin
                if (pfx.len > dmin_reg)
                begin
                    lmax_next  = lmax_reg << 1;
                    state_next = S_EXP_STEP;
                end
                else
                begin
                    l_next     = '0;
                    t_next     = lmax_reg >> 1;
                    state_next = S_BIN_STEP;
                end
            end

            S_BIN_STEP:
            begin
                if (t_reg == '0)
                begin
                    // probe_w holds the far end of the range here
                    if (dir_neg_reg)
                    begin
                        first_next = probe_w[rtnb_pkg::CNT_W-1:0];
                        last_next  = idx_reg;
                    end
                    else
                    begin
                        first_next = idx_reg;
                        last_next  = probe_w[rtnb_pkg::CNT_W-1:0];
                    end
                    state_next = S_SP_START;
                end
                else if (probe_ok)
                begin
                    addr_next  = probe_w;
                    ret_next   = S_BIN_EVAL;
                    state_next = S_READ;
                end
                else
                begin
                    t_next = t_reg >> 1;
                end
            end

            S_BIN_EVAL:
            begin
                if (pfx.len > dmin_reg)
                begin
                    l_next = l_reg + t_reg;
                end
                t_next     = t_reg >> 1;
                state_next = S_BIN_STEP;
            end

            S_SP_START:
            begin
                addr_next  = rtnb_pkg::to_probe(first_reg);
                ret_next   = S_SP_FC;
                state_next = S_READ;
            end

            S_SP_FC:
            begin
                base_next  = rdata_reg;
                addr_next  = rtnb_pkg::to_probe(last_reg);
                ret_next   = S_SP_LC;
                state_next = S_READ;
            end

            S_SP_LC:
            begin
                if (pfx.equal)
                begin
                    split_next = mid_sum[rtnb_pkg::CNT_W:1];
                    state_next = S_DONE;
                end
                else
                begin
                    common_next = pfx.len;
                    split_next  = first_reg;
                    step_next   = last_reg - first_reg;
                    state_next  = S_SP_STEP;
                end
            end

            S_SP_STEP:
            begin
                step_next = step_half;
                if (cand_sum < {1'b0, last_reg})
                begin
                    addr_next  = rtnb_pkg::to_probe(cand_sum[rtnb_pkg::CNT_W-1:0]);
                    ret_next   = S_SP_EVAL;
                    state_next = S_READ;
                end
                else if (step_half > pos_t'(1))
                begin
                    state_next = S_SP_STEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SP_EVAL:
            begin
                if (pfx.len > common_reg)
                begin
                    split_next = addr_reg[rtnb_pkg::CNT_W-1:0];
                end
                if (step_reg > pos_t'(1))
                begin
                    state_next = S_SP_STEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_count_reg <= rtnb_pkg::COUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            object_count_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        pd_reg      <= pd_next;
        dmin_reg    <= dmin_next;
        common_reg  <= common_next;
        eqd_reg     <= eqd_next;
        dir_neg_reg <= dir_neg_next;
        lmax_reg    <= lmax_next;
        l_reg       <= l_next;
        t_reg       <= t_next;
        step_reg    <= step_next;
        addr_reg    <= addr_next;
        idx_reg     <= idx_next;
        top_reg     <= top_next;
        j_reg       <= j_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        split_reg   <= split_next;
        if (rsp_load)
        begin
            rsp_reg.node_index     <= idx_reg[rtnb_pkg::IDX_W-1:0];
            rsp_reg.range_first    <= first_reg[rtnb_pkg::IDX_W-1:0];
            rsp_reg.range_last     <= last_reg[rtnb_pkg::IDX_W-1:0];
            rsp_reg.split_position <= split_reg[rtnb_pkg::IDX_W-1:0];
            rsp_reg.left_is_leaf   <= (split_reg == first_reg);
            rsp_reg.right_is_leaf  <= ({1'b0, split_reg} + 1'b1) == {1'b0, last_reg};
        end
    end

    // Code store: one write port for loads, one registered read port for the sequencer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= req.morton_code + rtnb_pkg::CODE_W'(req.item_index);
        end
        rdata_reg <= mem[mem_raddr];
    end

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |->
            (addr_reg >= 0) && (addr_reg <= rtnb_pkg::to_probe(top_reg)))
        else $error("code-store read outside the active leaves");

    a_split_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |->
            (first_reg <= split_reg) && (split_reg <= last_reg))
        else $error("split outside the node range");

    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!rsp_valid || rsp_ready)) |=>
            (rsp_valid && state_reg == S_IDLE))
        else $error("finished node not handed to the output register");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the hand-over state");

endmodule

FILE: sim/tb_radix_tree_node_builder_unit.sv
// Testbench for the radix tree node builder: directed table, then random code sets, checked per node.
`timescale 1ns / 1ps

module tb_radix_tree_node_builder_unit;

    localparam int SLOTS         = 1024;
    localparam int RANDOM_BEATS  = 600;
    localparam int SETTLE_CYCLES = 100;

    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_LOAD,
        ROW_BUILD
    } row_kind_t;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_FIXED,
        EXP_NONE
    } exp_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [9:0]      idx;
        logic [31:0]     value;
        exp_kind_t       chk;
        rtnb_pkg::rsp_t  want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    rtnb_pkg::req_t             req = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    rtnb_pkg::rsp_t             rsp;
    logic                       cfg_write_en = 1'b0;
    logic [rtnb_pkg::CNT_W-1:0] cfg_write_data = '0;

    logic [31:0]        code_mem [SLOTS];
    int                 active_objects = SLOTS;
    rtnb_pkg::rsp_t     pending_nodes [$];
    rtnb_pkg::rsp_t     head_node;
    stim_row_t          directed_rows [$];
    int                 mismatches = 0;
    int                 random_beats = 0;
    bit                 calm = 1'b0;

    radix_tree_node_builder_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    // ---------------------------------------------------------------- predictor

    function automatic int lead_zeros(logic [31:0] x);
        int n;
        n = 32;
        for (int b = 31; b >= 0; b--)
            if (x[b] && n == 32)
                n = 31 - b;
        return n;
    endfunction

    function automatic logic [31:0] code_at(int i);
        if (i < 0 || i >= SLOTS)
            return 32'd0;
        return code_mem[i];
    endfunction

    function automatic int objects_in_use(logic [rtnb_pkg::CNT_W-1:0] raw);
        if (raw < 2)
            return 2;
        if (raw > SLOTS)
            return SLOTS;
        return int'(raw);
    endfunction

    function automatic void node_span(input int idx, input int top, output int lo, output int hi);
        logic [31:0] c, up, dn;
        int          pu, pd, dir, dmin, lmax, l, j, p;
        if (idx == 0)
        begin
            lo = 0;
            hi = top;
            return;
        end
        c  = code_at(idx);
        up = code_at(idx + 1);
        dn = code_at(idx - 1);
        // inside a run of equal codes: scan upward to the end of the run
        if (c == dn && c == up)
        begin
            j = idx + 1;
            while (j < top && code_at(j) == code_at(j + 1))
                j++;
            lo = idx;
            hi = j;
            return;
        end
        pu = lead_zeros(c ^ up);
        pd = lead_zeros(c ^ dn);
        if (pu < pd)
        begin
            dir  = -1;
            dmin = pu;
        end
        else
        begin
            dir  = 1;
            dmin = pd;
        end
        lmax = 2;
        p = dmin + 1;
        while (p > dmin)
        begin
            j = idx + lmax * dir;
            p = -1;
            if (j >= 0 && j <= top)
                p = lead_zeros(c ^ code_at(j));
            if (p > dmin)
                lmax *= 2;
        end
        l = 0;
        for (int t = lmax / 2; t >= 1; t = t / 2)
        begin
            j = idx + (l + t) * dir;
            if (j >= 0 && j <= top && lead_zeros(c ^ code_at(j)) > dmin)
                l += t;
        end
        j = idx + l * dir;
        if (j < idx)
        begin
            lo = j;
            hi = idx;
        end
        else
        begin
            lo = idx;
            hi = j;
        end
    endfunction

    function automatic int split_of(int first, int last);
        logic [31:0] fc, lc;
        int          common, s, step, cand;
        fc = code_at(first);
        lc = code_at(last);
        if (fc == lc)
            return (first + last) / 2;
        common = lead_zeros(fc ^ lc);
        s = first;
        step = last - first;
        do
        begin
            step = (step + 1) / 2;
            cand = s + step;
            if (cand < last && lead_zeros(fc ^ code_at(cand)) > common)
                s = cand;
        end
        while (step > 1);
        return s;
    endfunction

    function automatic rtnb_pkg::rsp_t derive_node(int idx);
        rtnb_pkg::rsp_t r;
        int             first, last, split;
        node_span(idx, active_objects - 1, first, last);
        split = split_of(first, last);
        r.node_index     = 10'(idx);
        r.range_first    = 10'(first);
        r.range_last     = 10'(last);
        r.split_position = 10'(split);
        r.left_is_leaf   = (split == first);
        r.right_is_leaf  = (split + 1 == last);
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [9:0] got,
                               input logic [9:0] want);
        if (got !== want)
            report_mismatch($sformatf("node %0d %s: got %0d, expected %0d",
                                      head_node.node_index, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_nodes.size() == 0)
                report_mismatch($sformatf("result for node %0d with none expected",
                                          rsp.node_index));
            else
            begin
                head_node = pending_nodes.pop_front();
                check_field("node_index", rsp.node_index, head_node.node_index);
                check_field("range_first", rsp.range_first, head_node.range_first);
                check_field("range_last", rsp.range_last, head_node.range_last);
                check_field("split_position", rsp.split_position, head_node.split_position);
                check_field("left_is_leaf", {9'd0, rsp.left_is_leaf},
                            {9'd0, head_node.left_is_leaf});
                check_field("right_is_leaf", {9'd0, rsp.right_is_leaf},
                            {9'd0, head_node.right_is_leaf});
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic rtnb_pkg::req_t make_beat(rtnb_pkg::cmd_t cmd, int idx,
                                                 logic [31:0] code);
        rtnb_pkg::req_t r;
        r.command     = cmd;
        r.item_index  = 10'(idx);
        r.morton_code = code;
        return r;
    endfunction

    function automatic rtnb_pkg::rsp_t fixed_node(int n, int f, int l, int s,
                                                  logic ll, logic rl);
        rtnb_pkg::rsp_t r;
        r.node_index     = 10'(n);
        r.range_first    = 10'(f);
        r.range_last     = 10'(l);
        r.split_position = 10'(s);
        r.left_is_leaf   = ll;
        r.right_is_leaf  = rl;
        return r;
    endfunction

    function automatic void add_row(row_kind_t kind, int idx, logic [31:0] value,
                                    exp_kind_t chk, rtnb_pkg::rsp_t want);
        stim_row_t r;
        r.kind  = kind;
        r.idx   = 10'(idx);
        r.value = value;
        r.chk   = chk;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    // Present one beat, hold it until accepted, then update the code copy or queue the node.
    task automatic issue(input rtnb_pkg::req_t beat, input exp_kind_t chk,
                         input rtnb_pkg::rsp_t want);
        while (!calm && $urandom_range(0, 99) < 6)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do
            @(posedge clk);
        while (!req_ready);
        if (beat.command == rtnb_pkg::CMD_LOAD)
            code_mem[beat.item_index] = beat.morton_code + {22'd0, beat.item_index};
        else if (chk == EXP_FIXED)
            pending_nodes.push_back(want);
        else if (chk == EXP_MODEL && int'(beat.item_index) < active_objects - 1)
            pending_nodes.push_back(derive_node(beat.item_index));
    endtask

    // Drain, let any silent build finish, then write the count.
    task automatic set_object_count(input logic [rtnb_pkg::CNT_W-1:0] raw);
        req_valid <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= raw;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        active_objects = objects_in_use(raw);
    endtask

    initial
    begin
        longint unsigned            acc;
        logic [31:0]                stored;
        logic [rtnb_pkg::CNT_W-1:0] raw;
        int                         shift, pick, builds, roll;
        bit                         scrambled;

        for (int i = 0; i < SLOTS; i++)
            code_mem[i] = 32'd0;

        // node zero and the top node after reset, on evenly spread codes
        add_row(ROW_BUILD, 0, 0, EXP_FIXED, fixed_node(0, 0, 1023, 511, 1'b0, 1'b0));
        add_row(ROW_BUILD, 1022, 0, EXP_FIXED, fixed_node(1022, 1022, 1023, 1022, 1'b1, 1'b1));
        add_row(ROW_BUILD, 1023, 0, EXP_NONE, '0);
        // counts beyond the range clamp
        add_row(ROW_CONFIG, 0, 32'd2047, EXP_MODEL, '0);
        add_row(ROW_BUILD, 1022, 0, EXP_MODEL, '0);
        add_row(ROW_BUILD, 1023, 0, EXP_NONE, '0);
        add_row(ROW_CONFIG, 0, 32'd0, EXP_MODEL, '0);
        add_row(ROW_BUILD, 0, 0, EXP_FIXED, fixed_node(0, 0, 1, 0, 1'b1, 1'b1));
        add_row(ROW_BUILD, 1, 0, EXP_NONE, '0);
        add_row(ROW_CONFIG, 0, 32'd1, EXP_MODEL, '0);
        // stored code wraps past the top
        add_row(ROW_LOAD, 0, 32'hFFFF_FFFF, EXP_MODEL, '0);
        add_row(ROW_LOAD, 1, 32'hFFFF_FFFF, EXP_MODEL, '0);
        add_row(ROW_BUILD, 0, 0, EXP_FIXED, fixed_node(0, 0, 1, 0, 1'b1, 1'b1));
        // run of equal codes up to the last leaf
        add_row(ROW_CONFIG, 0, 32'd6, EXP_MODEL, '0);
        add_row(ROW_LOAD, 2, 32'h00C0_0000 - 32'd2, EXP_MODEL, '0);
        add_row(ROW_LOAD, 4, 32'h00C0_0000 - 32'd4, EXP_MODEL, '0);
        add_row(ROW_LOAD, 5, 32'h00C0_0000 - 32'd5, EXP_MODEL, '0);
        add_row(ROW_BUILD, 3, 0, EXP_FIXED, fixed_node(3, 3, 5, 4, 1'b0, 1'b1));
        add_row(ROW_BUILD, 4, 0, EXP_FIXED, fixed_node(4, 4, 5, 4, 1'b1, 1'b1));
        add_row(ROW_BUILD, 5, 0, EXP_NONE, '0);
        // unsorted: both neighbours share the same prefix with the node
        add_row(ROW_LOAD, 2, 32'h7FFF_FFFE, EXP_MODEL, '0);
        add_row(ROW_BUILD, 1, 0, EXP_MODEL, '0);
        add_row(ROW_LOAD, 1023, 32'd0, EXP_MODEL, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every slot so that no build reads an unwritten entry
        for (int i = 0; i < SLOTS; i++)
            issue(make_beat(rtnb_pkg::CMD_LOAD, i, (32'(i) << 22) - 32'(i)), EXP_MODEL, '0);

        foreach (directed_rows[r])
        begin
            case (directed_rows[r].kind)
                ROW_CONFIG: set_object_count(rtnb_pkg::CNT_W'(directed_rows[r].value));
                ROW_LOAD:   issue(make_beat(rtnb_pkg::CMD_LOAD, directed_rows[r].idx,
                                            directed_rows[r].value), EXP_MODEL, '0);
                default:    issue(make_beat(rtnb_pkg::CMD_BUILD, directed_rows[r].idx,
                                            $urandom),
                                  directed_rows[r].chk, directed_rows[r].want);
            endcase
        end

        while (random_beats < RANDOM_BEATS)
        begin
            calm <= (random_beats >= 200 && random_beats < 330);
            pick = $urandom_range(0, 15);
            if (pick == 0)
                raw = ($urandom_range(0, 1) != 0)
                    ? rtnb_pkg::CNT_W'(1024)
                    : rtnb_pkg::CNT_W'($urandom_range(1025, 2047));
            else if (pick == 1)
                raw = rtnb_pkg::CNT_W'($urandom_range(0, 2));
            else
                raw = rtnb_pkg::CNT_W'($urandom_range(3, 48));
            set_object_count(raw);

            // fresh sorted set with duplicates; now and then a scrambled one
            if (active_objects <= 64)
            begin
                scrambled = ($urandom_range(0, 7) == 0);
                acc   = $urandom >> $urandom_range(0, 31);
                shift = $urandom_range(0, 22);
                for (int i = 0; i < active_objects; i++)
                begin
                    if (scrambled)
                        stored = 32'($urandom_range(0, 7)) << 29;
                    else
                        stored = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                    issue(make_beat(rtnb_pkg::CMD_LOAD, i, stored - 32'(i)), EXP_MODEL, '0);
                    random_beats++;
                    if ($urandom_range(0, 3) != 0)
                        acc += longint'($urandom_range(1, 1023)) << shift;
                end
            end

            builds = $urandom_range(8, 40);
            for (int k = 0; k < builds; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    issue(make_beat(rtnb_pkg::CMD_LOAD, $urandom_range(0, SLOTS - 1),
                                    $urandom), EXP_MODEL, '0);
                else if (roll < 12)
                    issue(make_beat(rtnb_pkg::CMD_BUILD, $urandom_range(0, SLOTS - 1),
                                    $urandom), EXP_MODEL, '0);
                else
                    issue(make_beat(rtnb_pkg::CMD_BUILD,
                                    $urandom_range(0, active_objects - 2), $urandom),
                          EXP_MODEL, '0);
                random_beats++;
            end
        end

        req_valid <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
